/* rtl/psk_pkg.sv */
// Shared types, constants and message decode for the panel switch and knob qualifier.
package psk_pkg;

   // Reset values of the control registers
   localparam logic [15:0] SETTLE_MS_RESET     = 16'd50;
   localparam logic [31:0] BEAT_INTERVAL_RESET = 32'd10000;
   localparam logic [11:0] KNOB_DEADBAND_RESET = 12'd80;
   localparam logic [2:0]  ACTIVE_LOW_RESET    = 3'd7;
   localparam logic        KNOB_ENABLE_RESET   = 1'b1;
   localparam logic [7:0]  VERSION_RESET       = 8'd1;

   // Knob level before any start poll or report latched one
   localparam logic signed [12:0] KNOB_SETTLED_RESET = -13'sd1000;

   localparam int QUEUE_DEPTH = 2;

   // Control register indexes
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETTLE_MS     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BEAT_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOB_DEADBAND = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_LOW    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KNOB_ENABLE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION       = 3'd5;

   // Active-low mask bit per switch
   localparam int SW_DETECT = 0;
   localparam int SW_DEPTH  = 1;
   localparam int SW_BUTTON = 2;

   // Message kinds
   localparam logic [2:0] KIND_VERSION   = 3'd0;
   localparam logic [2:0] KIND_SPEECH    = 3'd1;
   localparam logic [2:0] KIND_VIBRATION = 3'd2;
   localparam logic [2:0] KIND_KNOB      = 3'd3;
   localparam logic [2:0] KIND_MODE      = 3'd4;
   localparam logic [2:0] KIND_STATUS    = 3'd5;
   localparam logic [2:0] KIND_ALIVE     = 3'd6;

   // Message slots of one poll, in output order
   localparam int SLOT_COUNT = 12;
   localparam int SLOT_W     = 4;

   typedef enum logic [SLOT_W-1:0] {
      SLOT_VERSION   = 4'd0,
      SLOT_SPEECH_A  = 4'd1,
      SLOT_VIBRATE_A = 4'd2,
      SLOT_KNOB_A    = 4'd3,
      SLOT_MODE_A    = 4'd4,
      SLOT_STATUS    = 4'd5,
      SLOT_KNOB_MOVE = 4'd6,
      SLOT_ALIVE     = 4'd7,
      SLOT_SPEECH_B  = 4'd8,
      SLOT_VIBRATE_B = 4'd9,
      SLOT_KNOB_B    = 4'd10,
      SLOT_MODE_B    = 4'd11
   } slot_type;

   typedef struct packed {
      logic        start_req;
      logic [31:0] time_ms;
      logic        detect_raw;
      logic        depth_raw;
      logic        button_raw;
      logic [11:0] knob_raw;
   } req_type;

   typedef struct packed {
      logic [2:0]  message_kind;
      logic [11:0] message_value;
      logic        last_of_poll;
   } rsp_type;

   typedef struct packed {
      logic [15:0] settle_ms;
      logic [31:0] beat_interval;
      logic [11:0] knob_deadband;
      logic [2:0]  active_low_mask;
      logic        knob_enable;
      logic [7:0]  version_code;
   } cfg_type;

   // One classified poll: which messages to send and the values they carry
   typedef struct packed {
      logic [SLOT_COUNT-1:0] slots;
      logic                  detect_on;
      logic                  depth_on;
      logic [11:0]           knob_value;
      logic [7:0]            version;
   } plan_type;

   function automatic rsp_type slot_message(input slot_type slot, input plan_type plan,
                                            input logic last);
      rsp_type msg;
      msg.last_of_poll  = last;
      msg.message_kind  = KIND_VERSION;
      msg.message_value = '0;
      unique case (slot)
         SLOT_VERSION: begin
            msg.message_kind  = KIND_VERSION;
            msg.message_value = {4'd0, plan.version};
         end
         SLOT_SPEECH_A, SLOT_SPEECH_B: begin
            msg.message_kind  = KIND_SPEECH;
            msg.message_value = {11'd0, plan.detect_on};
         end
         SLOT_VIBRATE_A, SLOT_VIBRATE_B: begin
            msg.message_kind  = KIND_VIBRATION;
            msg.message_value = {11'd0, plan.depth_on};
         end
         SLOT_KNOB_A, SLOT_KNOB_MOVE, SLOT_KNOB_B: begin
            msg.message_kind  = KIND_KNOB;
            msg.message_value = plan.knob_value;
         end
         SLOT_MODE_A, SLOT_MODE_B: begin
            msg.message_kind  = KIND_MODE;
            msg.message_value = {10'd0, plan.depth_on, plan.detect_on};
         end
         SLOT_STATUS: begin
            msg.message_kind  = KIND_STATUS;
         end
         SLOT_ALIVE: begin
            msg.message_kind  = KIND_ALIVE;
         end
         default: begin
            msg.message_kind  = KIND_VERSION;
         end
      endcase
      return msg;
   endfunction

endpackage

/* rtl/psk_front.sv */
// Front end: accepts polls, debounces switches, tracks knob and heartbeat, builds a plan.
module psk_front (
   input  logic               clock,
   input  logic               reset,
   input  psk_pkg::cfg_type   cfg,
   input  logic               req_valid,
   input  psk_pkg::req_type   req_payload,
   input  logic               queue_full,
   output logic               req_stall,
   output logic               push,
   output psk_pkg::plan_type  push_plan
);

   typedef struct packed {
      logic        stable;
      logic        seen;
      logic [31:0] changed_at;
      logic        moved;
   } sw_next_type;

   function automatic sw_next_type settle(input logic stable, input logic seen,
                                          input logic [31:0] changed_at,
                                          input logic level, input logic [31:0] now,
                                          input logic [15:0] hold);
      sw_next_type nxt;
      logic [31:0] elapsed;
      nxt.stable     = stable;
      nxt.seen       = seen;
      nxt.changed_at = changed_at;
      if (level != seen) begin
         nxt.seen       = level;
         nxt.changed_at = now;
      end
      elapsed   = now - nxt.changed_at;
      nxt.moved = (level != stable) && (elapsed > {16'd0, hold});
      if (nxt.moved) begin
         nxt.stable = level;
      end
      return nxt;
   endfunction

   logic                 det_stable_ff, det_stable_in, det_seen_ff, det_seen_in;
   logic                 dep_stable_ff, dep_stable_in, dep_seen_ff, dep_seen_in;
   logic                 btn_stable_ff, btn_stable_in, btn_seen_ff, btn_seen_in;
   logic [31:0]          det_changed_ff, det_changed_in;
   logic [31:0]          dep_changed_ff, dep_changed_in;
   logic [31:0]          btn_changed_ff, btn_changed_in;
   logic signed [12:0]   knob_settled_ff, knob_settled_in;
   logic [31:0]          beat_last_ff, beat_last_in;

   sw_next_type          det_nxt, dep_nxt, btn_nxt;
   logic                 accept;
   logic                 start;
   logic                 rocker_moved, status_press, knob_move, beat_due;
   logic signed [13:0]   knob_diff;
   logic [13:0]          knob_dist;
   logic [31:0]          beat_elapsed;
   logic                 det_on, dep_on;
   logic [psk_pkg::SLOT_COUNT-1:0] slots;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign start     = req_payload.start_req;

   always_comb begin
      det_nxt = settle(det_stable_ff, det_seen_ff, det_changed_ff, req_payload.detect_raw,
                       req_payload.time_ms, cfg.settle_ms);
      dep_nxt = settle(dep_stable_ff, dep_seen_ff, dep_changed_ff, req_payload.depth_raw,
                       req_payload.time_ms, cfg.settle_ms);
      btn_nxt = settle(btn_stable_ff, btn_seen_ff, btn_changed_ff, req_payload.button_raw,
                       req_payload.time_ms, cfg.settle_ms);

      knob_diff = $signed({2'b00, req_payload.knob_raw})
                - $signed({knob_settled_ff[12], knob_settled_ff});
      knob_dist = knob_diff[13] ? 14'(-knob_diff) : 14'(knob_diff);
      beat_elapsed = req_payload.time_ms - beat_last_ff;

      rocker_moved = det_nxt.moved || dep_nxt.moved;
      status_press = btn_nxt.moved && (btn_nxt.stable ^ cfg.active_low_mask[psk_pkg::SW_BUTTON]);
      knob_move    = cfg.knob_enable && (knob_dist > {2'b00, cfg.knob_deadband});
      beat_due     = beat_elapsed >= cfg.beat_interval;

      // defaults: hold state
      det_stable_in   = det_stable_ff;
      det_seen_in     = det_seen_ff;
      det_changed_in  = det_changed_ff;
      dep_stable_in   = dep_stable_ff;
      dep_seen_in     = dep_seen_ff;
      dep_changed_in  = dep_changed_ff;
      btn_stable_in   = btn_stable_ff;
      btn_seen_in     = btn_seen_ff;
      btn_changed_in  = btn_changed_ff;
      knob_settled_in = knob_settled_ff;
      beat_last_in    = beat_last_ff;
      slots           = '0;

      if (start) begin
         det_stable_in = req_payload.detect_raw;
         det_seen_in   = req_payload.detect_raw;
         dep_stable_in = req_payload.depth_raw;
         dep_seen_in   = req_payload.depth_raw;
         if (cfg.knob_enable) begin
            knob_settled_in = $signed({1'b0, req_payload.knob_raw});
         end
         slots[psk_pkg::SLOT_VERSION]   = 1'b1;
         slots[psk_pkg::SLOT_SPEECH_A]  = 1'b1;
         slots[psk_pkg::SLOT_VIBRATE_A] = 1'b1;
         slots[psk_pkg::SLOT_KNOB_A]    = cfg.knob_enable;
         slots[psk_pkg::SLOT_MODE_A]    = 1'b1;
      end else begin
         det_stable_in  = det_nxt.stable;
         det_seen_in    = det_nxt.seen;
         det_changed_in = det_nxt.changed_at;
         dep_stable_in  = dep_nxt.stable;
         dep_seen_in    = dep_nxt.seen;
         dep_changed_in = dep_nxt.changed_at;
         btn_stable_in  = btn_nxt.stable;
         btn_seen_in    = btn_nxt.seen;
         btn_changed_in = btn_nxt.changed_at;
         if (knob_move) begin
            knob_settled_in = $signed({1'b0, req_payload.knob_raw});
         end
         if (beat_due) begin
            beat_last_in = req_payload.time_ms;
         end
         slots[psk_pkg::SLOT_SPEECH_A]  = rocker_moved;
         slots[psk_pkg::SLOT_VIBRATE_A] = rocker_moved;
         slots[psk_pkg::SLOT_MODE_A]    = rocker_moved;
         slots[psk_pkg::SLOT_STATUS]    = status_press;
         slots[psk_pkg::SLOT_KNOB_MOVE] = knob_move;
         slots[psk_pkg::SLOT_ALIVE]     = beat_due;
         slots[psk_pkg::SLOT_SPEECH_B]  = beat_due;
         slots[psk_pkg::SLOT_VIBRATE_B] = beat_due;
         slots[psk_pkg::SLOT_KNOB_B]    = beat_due && cfg.knob_enable;
         slots[psk_pkg::SLOT_MODE_B]    = beat_due;
      end

      det_on = det_stable_in ^ cfg.active_low_mask[psk_pkg::SW_DETECT];
      dep_on = dep_stable_in ^ cfg.active_low_mask[psk_pkg::SW_DEPTH];

      push_plan.slots      = slots;
      push_plan.detect_on  = det_on;
      push_plan.depth_on   = dep_on;
      // never-latched knob reads as zero
      push_plan.knob_value = knob_settled_in[12] ? 12'd0 : knob_settled_in[11:0];
      push_plan.version    = cfg.version_code;
      push                 = accept && (slots != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         det_stable_ff   <= 1'b1;
         det_seen_ff     <= 1'b1;
         det_changed_ff  <= '0;
         dep_stable_ff   <= 1'b1;
         dep_seen_ff     <= 1'b1;
         dep_changed_ff  <= '0;
         btn_stable_ff   <= 1'b1;
         btn_seen_ff     <= 1'b1;
         btn_changed_ff  <= '0;
         knob_settled_ff <= psk_pkg::KNOB_SETTLED_RESET;
         beat_last_ff    <= '0;
      end else if (accept) begin
         det_stable_ff   <= det_stable_in;
         det_seen_ff     <= det_seen_in;
         det_changed_ff  <= det_changed_in;
         dep_stable_ff   <= dep_stable_in;
         dep_seen_ff     <= dep_seen_in;
         dep_changed_ff  <= dep_changed_in;
         btn_stable_ff   <= btn_stable_in;
         btn_seen_ff     <= btn_seen_in;
         btn_changed_ff  <= btn_changed_in;
         knob_settled_ff <= knob_settled_in;
         beat_last_ff    <= beat_last_in;
      end
   end

   // A start poll always queues a version message
   a_start_pushes_version: assert property (@(posedge clock) disable iff (reset)
      accept && start |-> push && push_plan.slots[psk_pkg::SLOT_VERSION])
      else $error("start poll did not queue a version message");

   // The debounced level never changes except on an accepted poll
   a_stable_holds_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(det_stable_ff) && $stable(dep_stable_ff) && $stable(btn_stable_ff))
      else $error("switch state moved without a poll");

endmodule

/* rtl/psk_queue.sv */
// Small plan queue between the front end and the message sequencer.
module psk_queue #(
   parameter int Depth = psk_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  psk_pkg::plan_type  push_plan,
   output logic               full,
   output logic               pop_valid,
   output psk_pkg::plan_type  pop_plan,
   input  logic               pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   psk_pkg::plan_type entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full      = (count_ff == CntW'(Depth));
   assign pop_valid = (count_ff != '0);
   assign pop_plan  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_plan;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("plan queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("plan queue underflow");

endmodule

/* rtl/psk_back.sv */
// Back end: walks the slots of each plan and sends one message per transfer.
module psk_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   input  psk_pkg::plan_type  pop_plan,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output psk_pkg::rsp_type   rsp_payload
);

   logic [psk_pkg::SLOT_COUNT-1:0] pend_ff, pend_in;
   psk_pkg::plan_type              plan_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   psk_pkg::rsp_type               rsp_ff, rsp_in;

   logic [psk_pkg::SLOT_COUNT-1:0] first_bit, pend_after;
   logic [psk_pkg::SLOT_W-1:0]     slot_idx;
   logic                           busy, out_ready, emit, load;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      busy       = (pend_ff != '0);
      out_ready  = !rsp_valid_ff || !rsp_stall;
      emit       = busy && out_ready;
      first_bit  = pend_ff & (~pend_ff + 1'b1);
      pend_after = pend_ff & ~first_bit;
      slot_idx   = '0;
      for (int i = 0; i < psk_pkg::SLOT_COUNT; i++) begin
         if (first_bit[i]) begin
            slot_idx = slot_idx | psk_pkg::SLOT_W'(i);
         end
      end

      load = pop_valid && (!busy || (emit && (pend_after == '0)));
      pop  = load;

      if (load) begin
         pend_in = pop_plan.slots;
      end else if (emit) begin
         pend_in = pend_after;
      end else begin
         pend_in = pend_ff;
      end

      rsp_valid_in = out_ready ? emit : rsp_valid_ff;
      rsp_in = emit ? psk_pkg::slot_message(psk_pkg::slot_type'(slot_idx), plan_ff,
                                            pend_after == '0)
                    : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         plan_ff <= pop_plan;
      end
      rsp_ff <= rsp_in;
   end

   // A message that is not the last of its poll leaves slots behind
   a_more_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last_of_poll |-> busy)
      else $error("poll ended without a last message");

   // A fresh plan is only taken once the current one has sent its last message
   a_load_when_done: assert property (@(posedge clock) disable iff (reset)
      load |-> !busy || (emit && pend_after == '0))
      else $error("plan overwritten while messages remain");

endmodule

/* rtl/panel_switch_knob_qualifier.sv */
// Top level of the panel switch and knob qualifier: control registers and the three stages.
//
// Each poll carries a millisecond timestamp, the raw levels of the detect and
// depth rockers and of the status button, a 12-bit knob sample and a start
// flag. The front end takes one poll per cycle while the queue is not full,
// debounces each switch against the settle time (elapsed time is wrap-safe),
// checks the knob against the deadband and the heartbeat against its
// interval, and turns the poll into a plan of up to ten messages with their
// values already fixed. Plans wait in a small queue (QueueDepth entries); the
// back end sends one message per rsp transfer, flagging the final message of
// each poll with last_of_poll. Polls that produce no message are absorbed
// without a trace on rsp. The back end takes the next plan as it sends the
// last message of the current one, so sustained throughput is one message
// per cycle while rsp_stall is low; req_stall rises only when the queue is
// full. From an idle block, a poll passes the queue entry, the plan load and
// the output register before rsp_valid rises. Control registers are written
// through csr_write_en / csr_index / csr_wdata and must only change while
// the block is idle; unused index values are ignored.
module panel_switch_knob_qualifier #(
   parameter int QueueDepth = psk_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  psk_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output psk_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_write_en,
   input  logic [psk_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [psk_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   psk_pkg::cfg_type  cfg_ff, cfg_in;
   logic              push, queue_full, pop_valid, pop;
   psk_pkg::plan_type push_plan, pop_plan;

   // control register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            psk_pkg::CSR_SETTLE_MS:     cfg_in.settle_ms        = csr_wdata[15:0];
            psk_pkg::CSR_BEAT_INTERVAL: cfg_in.beat_interval    = csr_wdata[31:0];
            psk_pkg::CSR_KNOB_DEADBAND: cfg_in.knob_deadband    = csr_wdata[11:0];
            psk_pkg::CSR_ACTIVE_LOW:    cfg_in.active_low_mask  = csr_wdata[2:0];
            psk_pkg::CSR_KNOB_ENABLE:   cfg_in.knob_enable      = csr_wdata[0];
            psk_pkg::CSR_VERSION:       cfg_in.version_code     = csr_wdata[7:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.settle_ms       <= psk_pkg::SETTLE_MS_RESET;
         cfg_ff.beat_interval   <= psk_pkg::BEAT_INTERVAL_RESET;
         cfg_ff.knob_deadband   <= psk_pkg::KNOB_DEADBAND_RESET;
         cfg_ff.active_low_mask <= psk_pkg::ACTIVE_LOW_RESET;
         cfg_ff.knob_enable     <= psk_pkg::KNOB_ENABLE_RESET;
         cfg_ff.version_code    <= psk_pkg::VERSION_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // classify polls
   psk_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .req_stall   (req_stall),
      .push        (push),
      .push_plan   (push_plan)
   );

   // decouple poll intake from message output
   psk_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_plan (push_plan),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_plan  (pop_plan),
      .pop       (pop)
   );

   // sequence messages
   psk_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_plan    (pop_plan),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
